@@ hdl/bsoc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Battery SoC package
// Shared widths, register codes, reset values and the two constant
// open-circuit-voltage curves used by the state-of-charge lookup.
// ----------------------------------------------------------------------------
package bsoc_pkg;

   // field widths
   localparam int unsigned MV_W   = 13;
   localparam int unsigned MA_W   = 13;
   localparam int unsigned RES_W  = 10;
   localparam int unsigned PCT_W  = 7;
   localparam int unsigned PROD_W = MA_W + RES_W;

   // configuration port
   localparam int unsigned ADDR_W = 4;
   localparam int unsigned DATA_W = 32;

   typedef enum logic [1:0] {
      REG_BATTERY_SELECT = 2'd0,
      REG_RES_FIRST      = 2'd1,
      REG_RES_SECOND     = 2'd2
   } reg_addr_type;

   localparam logic             SELECT_RESET     = 1'b1;
   localparam logic [RES_W-1:0] RES_FIRST_RESET  = 10'd300;
   localparam logic [RES_W-1:0] RES_SECOND_RESET = 10'd280;

   // queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // divide by 1000: drop product by 8 first, then multiply by ceil(2^26/125)
   localparam int unsigned PRE_SHIFT   = 3;
   localparam int unsigned SCALED_W    = PROD_W - PRE_SHIFT;
   localparam int unsigned RECIP_W     = 20;
   localparam logic [RECIP_W-1:0] RECIP_125 = 20'd536871;
   localparam int unsigned RECIP_SHIFT = 26;
   localparam int unsigned QUOT_W      = SCALED_W + RECIP_W;
   localparam int unsigned DROP_W      = 14;

   localparam logic [MV_W-1:0] MV_MAX = 13'd8191;

   // curve tables, index 0 = first battery, 1 = second battery
   localparam int unsigned CURVE_POINTS = 14;
   localparam int unsigned IDX_W        = 4;
   localparam int unsigned OFFSET_W     = 8;
   localparam int unsigned STEP_RCP_W   = 16;
   localparam int unsigned INTERP_W     = OFFSET_W + STEP_RCP_W;
   localparam int unsigned INTERP_SHIFT = 16;

   localparam logic [IDX_W-1:0] CURVE_LEN [2] = '{4'd13, 4'd14};

   // first curve is padded with a zero-voltage point that never matches first
   localparam logic [MV_W-1:0] CURVE_MV [2][CURVE_POINTS] = '{
      '{13'd4321, 13'd4152, 13'd4096, 13'd4030, 13'd3974, 13'd3920, 13'd3868,
        13'd3804, 13'd3764, 13'd3721, 13'd3679, 13'd3653, 13'd3628, 13'd0},
      '{13'd4227, 13'd4154, 13'd4117, 13'd4042, 13'd3986, 13'd3954, 13'd3901,
        13'd3844, 13'd3782, 13'd3714, 13'd3671, 13'd3652, 13'd3635, 13'd3608}
   };

   localparam logic [PCT_W-1:0] CURVE_PCT [2][CURVE_POINTS] = '{
      '{7'd100, 7'd94, 7'd88, 7'd84, 7'd73, 7'd65, 7'd56,
        7'd45,  7'd33, 7'd20, 7'd13, 7'd9,  7'd0,  7'd0},
      '{7'd100, 7'd95, 7'd88, 7'd82, 7'd76, 7'd69, 7'd61,
        7'd52,  7'd43, 7'd34, 7'd25, 7'd18, 7'd10, 7'd0}
   };

   // ceil(2^16 / step) for the segment that ends at each point, where
   // step = span_mv / span_pct (integer); exact for offsets within a segment
   localparam logic [STEP_RCP_W-1:0] CURVE_RCP [2][CURVE_POINTS] = '{
      '{16'd0,     16'd2341,  16'd7282,  16'd4096,  16'd13108, 16'd10923, 16'd13108,
        16'd13108, 16'd21846, 16'd21846, 16'd10923, 16'd10923, 16'd32768, 16'd0},
      '{16'd0,     16'd4682,  16'd13108, 16'd5462,  16'd7282,  16'd16384, 16'd10923,
        16'd10923, 16'd10923, 16'd9363,  16'd16384, 16'd32768, 16'd32768, 16'd32768}
   };

   // one queued transaction
   typedef struct packed {
      logic [MV_W-1:0]   battery_mv;
      logic              charging;
      logic              sel;
      logic [PROD_W-1:0] product;
   } item_type;

endpackage
`default_nettype wire

@@ hdl/bsoc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Battery SoC front end
// Accepts a reading, picks the battery's resistance and registers the
// current-resistance product for the queue.
// ----------------------------------------------------------------------------
module bsoc_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [bsoc_pkg::MV_W-1:0]            req_battery_mv,
   input  wire  [bsoc_pkg::MA_W-1:0]            req_battery_ma,
   input  wire                                  req_charging,
   input  wire                                  battery_select,
   input  wire  [bsoc_pkg::RES_W-1:0]           res_first,
   input  wire  [bsoc_pkg::RES_W-1:0]           res_second,
   output logic                                 push_valid,
   output bsoc_pkg::item_type                   push_item,
   input  wire                                  queue_full
);

   logic                        valid_ff, valid_in;
   bsoc_pkg::item_type          item_ff, item_in;
   logic [bsoc_pkg::RES_W-1:0]  res;
   logic                        advance;

   // stage moves when empty or when the queue takes its transaction
   assign advance   = !valid_ff || !queue_full;
   assign req_stall = !advance;

   assign res = battery_select ? res_second : res_first;

   always_comb begin
      valid_in           = req_valid;
      item_in.battery_mv = req_battery_mv;
      item_in.charging   = req_charging;
      item_in.sel        = battery_select;
      item_in.product    = bsoc_pkg::PROD_W'(req_battery_ma) * bsoc_pkg::PROD_W'(res);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule
`default_nettype wire

@@ hdl/bsoc_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Battery SoC queue
// Short FIFO that decouples the front end from the back-end pipeline.
// ----------------------------------------------------------------------------
module bsoc_queue #(
   parameter int unsigned DEPTH = bsoc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_valid,
   input  bsoc_pkg::item_type  push_item,
   output logic                full,
   output logic                pop_valid,
   input  wire                 pop_ready,
   output bsoc_pkg::item_type  pop_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   bsoc_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   assign push = push_valid && !full;
   assign pop  = pop_ready && pop_valid;

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

@@ hdl/bsoc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Battery SoC back end
// Divides the drop by 1000, compensates the voltage, finds the curve segment,
// interpolates and holds the result in the output register.
// ----------------------------------------------------------------------------
module bsoc_back (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               pop_valid,
   input  bsoc_pkg::item_type                pop_item,
   output logic                              pop_ready,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [bsoc_pkg::MV_W-1:0]         rsp_compensated_mv,
   output logic [bsoc_pkg::PCT_W-1:0]        rsp_soc_percent
);

   localparam int unsigned MV_W   = bsoc_pkg::MV_W;
   localparam int unsigned PCT_W  = bsoc_pkg::PCT_W;
   localparam int unsigned IDX_W  = bsoc_pkg::IDX_W;
   localparam int unsigned DROP_W = bsoc_pkg::DROP_W;

   logic advance;

   // stage 1: reciprocal multiply for the divide by 1000
   logic                         s1_valid_ff;
   logic [MV_W-1:0]              s1_mv_ff;
   logic                         s1_chg_ff, s1_sel_ff;
   logic [bsoc_pkg::QUOT_W-1:0]  s1_quot_ff, s1_quot_in;

   // stage 2: compensated voltage
   logic                         s2_valid_ff;
   logic                         s2_sel_ff;
   logic [MV_W-1:0]              s2_comp_ff, s2_comp_in;
   logic [DROP_W-1:0]            drop;
   logic [DROP_W:0]              sum;

   // stage 3: segment index
   logic                         s3_valid_ff;
   logic                         s3_sel_ff;
   logic [MV_W-1:0]              s3_comp_ff;
   logic [IDX_W-1:0]             s3_idx_ff, s3_idx_in;

   // stage 4: interpolation product
   logic                            s4_valid_ff;
   logic [MV_W-1:0]                 s4_comp_ff;
   logic [PCT_W-1:0]                s4_top_ff, s4_top_in;
   logic [bsoc_pkg::INTERP_W-1:0]   s4_prod_ff, s4_prod_in;
   logic [IDX_W-1:0]                idx_prev;
   logic [MV_W-1:0]                 offset_full;

   // output register
   logic                         out_valid_ff;
   logic [MV_W-1:0]              out_mv_ff;
   logic [PCT_W-1:0]             out_pct_ff, out_pct_in;
   logic [bsoc_pkg::OFFSET_W-1:0] dec;

   // whole pipeline moves while the output slot is free or being taken
   assign advance   = !out_valid_ff || !rsp_stall;
   assign pop_ready = advance;

   // stage 1 datapath
   assign s1_quot_in =
      bsoc_pkg::QUOT_W'(pop_item.product[bsoc_pkg::PROD_W-1:bsoc_pkg::PRE_SHIFT]) *
      bsoc_pkg::QUOT_W'(bsoc_pkg::RECIP_125);

   // stage 2 datapath: saturating add or subtract of the drop
   assign drop = s1_quot_ff[bsoc_pkg::RECIP_SHIFT +: DROP_W];
   assign sum  = (DROP_W + 1)'(s1_mv_ff) + (DROP_W + 1)'(drop);

   always_comb begin
      if (s1_chg_ff) begin
         if (drop >= DROP_W'(s1_mv_ff)) begin
            s2_comp_in = '0;
         end else begin
            s2_comp_in = s1_mv_ff - MV_W'(drop);
         end
      end else begin
         if (sum > (DROP_W + 1)'(bsoc_pkg::MV_MAX)) begin
            s2_comp_in = bsoc_pkg::MV_MAX;
         end else begin
            s2_comp_in = MV_W'(sum);
         end
      end
   end

   // stage 3 datapath: first point at or below the voltage, or table length
   always_comb begin
      s3_idx_in = bsoc_pkg::CURVE_LEN[s2_sel_ff];
      for (int k = bsoc_pkg::CURVE_POINTS - 1; k >= 0; k--) begin
         if (s2_comp_ff >= bsoc_pkg::CURVE_MV[s2_sel_ff][k]) begin
            s3_idx_in = IDX_W'(k);
         end
      end
   end

   // stage 4 datapath: above top, below bottom, or inside a segment
   assign idx_prev    = s3_idx_ff - 1'b1;
   assign offset_full = bsoc_pkg::CURVE_MV[s3_sel_ff][idx_prev] - s3_comp_ff;

   always_comb begin
      if (s3_idx_ff == '0) begin
         s4_top_in  = bsoc_pkg::CURVE_PCT[s3_sel_ff][0];
         s4_prod_in = '0;
      end else if (s3_idx_ff == bsoc_pkg::CURVE_LEN[s3_sel_ff]) begin
         s4_top_in  = bsoc_pkg::CURVE_PCT[s3_sel_ff][idx_prev];
         s4_prod_in = '0;
      end else begin
         s4_top_in  = bsoc_pkg::CURVE_PCT[s3_sel_ff][idx_prev];
         s4_prod_in = bsoc_pkg::INTERP_W'(offset_full[bsoc_pkg::OFFSET_W-1:0]) *
                      bsoc_pkg::INTERP_W'(bsoc_pkg::CURVE_RCP[s3_sel_ff][s3_idx_ff]);
      end
   end

   // output datapath: step count off the top percent, clamped at zero
   assign dec = s4_prod_ff[bsoc_pkg::INTERP_SHIFT +: bsoc_pkg::OFFSET_W];

   always_comb begin
      if (dec >= bsoc_pkg::OFFSET_W'(s4_top_ff)) begin
         out_pct_in = '0;
      end else begin
         out_pct_in = s4_top_ff - PCT_W'(dec);
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= pop_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mv_ff   <= pop_item.battery_mv;
         s1_chg_ff  <= pop_item.charging;
         s1_sel_ff  <= pop_item.sel;
         s1_quot_ff <= s1_quot_in;

         s2_sel_ff  <= s1_sel_ff;
         s2_comp_ff <= s2_comp_in;

         s3_sel_ff  <= s2_sel_ff;
         s3_comp_ff <= s2_comp_ff;
         s3_idx_ff  <= s3_idx_in;

         s4_comp_ff <= s3_comp_ff;
         s4_top_ff  <= s4_top_in;
         s4_prod_ff <= s4_prod_in;

         out_mv_ff  <= s4_comp_ff;
         out_pct_ff <= out_pct_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_compensated_mv = out_mv_ff;
   assign rsp_soc_percent    = out_pct_ff;

endmodule
`default_nettype wire

@@ hdl/battery_soc_from_voltage_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Battery state-of-charge from voltage
// Compensates a battery reading for internal resistance and maps the
// open-circuit voltage to a percentage through a piecewise-linear curve.
// ----------------------------------------------------------------------------
//   channel   direction  handshake           payload
//   req_      in         req_valid/stall     battery_mv, battery_ma, charging
//   rsp_      out        rsp_valid/stall     compensated_mv, soc_percent
//   config    in         psel/penable/pwrite paddr, pwdata, prdata, pready
//
// One transaction per cycle sustained while no stall holds the flow; a result
// passes front register, queue, back-end stages 1 to 4 and output register.
// Reset empties the pipeline and loads the register defaults; no memory sweep.
// An rsp_stall holds the back end; the queue lets the front keep accepting
// until it fills, and only then does req_stall rise.
// ----------------------------------------------------------------------------
module battery_soc_from_voltage_core #(
   parameter int unsigned QUEUE_DEPTH = bsoc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // input channel
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [bsoc_pkg::MV_W-1:0]            req_battery_mv,
   input  wire  [bsoc_pkg::MA_W-1:0]            req_battery_ma,
   input  wire                                  req_charging,
   // result channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [bsoc_pkg::MV_W-1:0]            rsp_compensated_mv,
   output logic [bsoc_pkg::PCT_W-1:0]           rsp_soc_percent,
   // configuration port
   input  wire                                  psel,
   input  wire                                  penable,
   input  wire                                  pwrite,
   input  wire  [bsoc_pkg::ADDR_W-1:0]          paddr,
   input  wire  [bsoc_pkg::DATA_W-1:0]          pwdata,
   output logic [bsoc_pkg::DATA_W-1:0]          prdata,
   output logic                                 pready
);

   localparam int unsigned RES_W = bsoc_pkg::RES_W;

   logic                         select_ff;
   logic [RES_W-1:0]             res_first_ff, res_second_ff;
   logic                         cfg_write;
   bsoc_pkg::reg_addr_type       reg_addr;

   logic                         push_valid, queue_full;
   bsoc_pkg::item_type           push_item, pop_item;
   logic                         pop_valid, pop_ready;

   // configuration registers
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign reg_addr  = bsoc_pkg::reg_addr_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff     <= bsoc_pkg::SELECT_RESET;
         res_first_ff  <= bsoc_pkg::RES_FIRST_RESET;
         res_second_ff <= bsoc_pkg::RES_SECOND_RESET;
      end else if (cfg_write) begin
         case (reg_addr)
            bsoc_pkg::REG_BATTERY_SELECT: select_ff     <= pwdata[0];
            bsoc_pkg::REG_RES_FIRST:      res_first_ff  <= pwdata[RES_W-1:0];
            bsoc_pkg::REG_RES_SECOND:     res_second_ff <= pwdata[RES_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (reg_addr)
         bsoc_pkg::REG_BATTERY_SELECT: prdata = bsoc_pkg::DATA_W'(select_ff);
         bsoc_pkg::REG_RES_FIRST:      prdata = bsoc_pkg::DATA_W'(res_first_ff);
         bsoc_pkg::REG_RES_SECOND:     prdata = bsoc_pkg::DATA_W'(res_second_ff);
         default:                      prdata = '0;
      endcase
   end

   // front end: accept and form the drop product
   bsoc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_battery_mv (req_battery_mv),
      .req_battery_ma (req_battery_ma),
      .req_charging   (req_charging),
      .battery_select (select_ff),
      .res_first      (res_first_ff),
      .res_second     (res_second_ff),
      .push_valid     (push_valid),
      .push_item      (push_item),
      .queue_full     (queue_full)
   );

   // decoupling queue
   bsoc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // back end: compensation, lookup and interpolation
   bsoc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_item           (pop_item),
      .pop_ready          (pop_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_compensated_mv (rsp_compensated_mv),
      .rsp_soc_percent    (rsp_soc_percent)
   );

endmodule
`default_nettype wire

@@ tb/sv/bsoc_reading_checker.sv @@
// ----------------------------------------------------------------------------
// Battery SoC reading checker
// Watches the request, result and register ports of the SoC core. Keeps its
// own copy of the register set, works out the compensated voltage and charge
// percent for every accepted request transaction, and compares each accepted
// result transaction against the oldest outstanding reading. Register reads
// are checked against the local register copy.
// ----------------------------------------------------------------------------
module bsoc_reading_checker (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire                          req_stall,
   input  wire  [bsoc_pkg::MV_W-1:0]    req_battery_mv,
   input  wire  [bsoc_pkg::MA_W-1:0]    req_battery_ma,
   input  wire                          req_charging,
   input  wire                          rsp_valid,
   input  wire                          rsp_stall,
   input  wire  [bsoc_pkg::MV_W-1:0]    rsp_compensated_mv,
   input  wire  [bsoc_pkg::PCT_W-1:0]   rsp_soc_percent,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire  [bsoc_pkg::ADDR_W-1:0]  paddr,
   input  wire  [bsoc_pkg::DATA_W-1:0]  pwdata,
   input  wire  [bsoc_pkg::DATA_W-1:0]  prdata,
   input  wire                          pready,
   output int unsigned                  mismatch_count,
   output int unsigned                  readings_outstanding
);
   import bsoc_pkg::*;

   typedef struct packed {
      logic [MV_W-1:0]  compensated_mv;
      logic [PCT_W-1:0] soc_percent;
   } soc_reading_type;

   localparam int unsigned MOHM_PER_OHM = 1000;
   localparam int unsigned MV_CEILING   = 8191;
   localparam int unsigned FIRST_LEN    = 13;
   localparam int unsigned SECOND_LEN   = 14;

   // open-circuit voltage curves, highest voltage first
   localparam int unsigned FIRST_MV [FIRST_LEN] = '{
      4321, 4152, 4096, 4030, 3974, 3920, 3868, 3804, 3764, 3721, 3679, 3653, 3628};
   localparam int unsigned FIRST_PCT [FIRST_LEN] = '{
      100, 94, 88, 84, 73, 65, 56, 45, 33, 20, 13, 9, 0};
   localparam int unsigned SECOND_MV [SECOND_LEN] = '{
      4227, 4154, 4117, 4042, 3986, 3954, 3901, 3844, 3782, 3714, 3671, 3652, 3635, 3608};
   localparam int unsigned SECOND_PCT [SECOND_LEN] = '{
      100, 95, 88, 82, 76, 69, 61, 52, 43, 34, 25, 18, 10, 0};

   // local register copy
   logic             select_q;
   logic [RES_W-1:0] res_first_q;
   logic [RES_W-1:0] res_second_q;

   soc_reading_type readings_due [$];

   function automatic int unsigned point_mv(logic sel, int unsigned idx);
      if (sel) return SECOND_MV[idx];
      if (idx < FIRST_LEN) return FIRST_MV[idx];
      return 0;
   endfunction

   function automatic int unsigned point_pct(logic sel, int unsigned idx);
      if (sel) return SECOND_PCT[idx];
      if (idx < FIRST_LEN) return FIRST_PCT[idx];
      return 0;
   endfunction

   // piecewise-linear lookup with the integer per-percent step
   function automatic logic [PCT_W-1:0] ocv_percent(logic sel, int unsigned v);
      int unsigned n, idx, span_mv, span_pct, step, offset, dec;
      n = sel ? SECOND_LEN : FIRST_LEN;
      idx = 0;
      while (idx < n && v < point_mv(sel, idx)) idx++;
      if (idx == 0) return PCT_W'(point_pct(sel, 0));
      if (idx == n) return PCT_W'(point_pct(sel, n - 1));
      span_mv  = point_mv(sel, idx - 1) - point_mv(sel, idx);
      span_pct = point_pct(sel, idx - 1) - point_pct(sel, idx);
      step = (span_pct != 0) ? span_mv / span_pct : 0;
      if (step == 0) step = 1;
      offset = point_mv(sel, idx - 1) - v;
      dec = offset / step;
      if (dec >= point_pct(sel, idx - 1)) return '0;
      return PCT_W'(point_pct(sel, idx - 1) - dec);
   endfunction

   // resistance compensation, saturated, then curve lookup
   function automatic soc_reading_type compensated_reading(logic [MV_W-1:0] mv,
                                                           logic [MA_W-1:0] ma,
                                                           logic chg);
      int unsigned res, drop, mv_i, comp;
      soc_reading_type r;
      res  = 32'(select_q ? res_second_q : res_first_q);
      mv_i = 32'(mv);
      drop = (32'(ma) * res) / MOHM_PER_OHM;
      if (chg) begin
         comp = (drop >= mv_i) ? 0 : mv_i - drop;
      end else begin
         comp = (mv_i + drop > MV_CEILING) ? MV_CEILING : mv_i + drop;
      end
      r.compensated_mv = comp[MV_W-1:0];
      r.soc_percent    = ocv_percent(select_q, comp);
      return r;
   endfunction

   always @(posedge clock) begin
      soc_reading_type want;
      int unsigned errs;
      logic [DATA_W-1:0] reg_now;
      logic mapped;
      errs = 0;
      if (reset) begin
         select_q     = 1'b1;
         res_first_q  = 10'd300;
         res_second_q = 10'd280;
         readings_due.delete();
         mismatch_count       <= 0;
         readings_outstanding <= 0;
      end else begin
         // result transaction against the oldest reading
         if (rsp_valid && !rsp_stall) begin
            if (readings_due.size() == 0) begin
               $display("%0t: unexpected result mv=%0d pct=%0d", $time,
                        rsp_compensated_mv, rsp_soc_percent);
               errs++;
            end else begin
               want = readings_due.pop_front();
               if (rsp_compensated_mv !== want.compensated_mv) begin
                  $display("%0t: compensated_mv expected %0d actual %0d", $time,
                           want.compensated_mv, rsp_compensated_mv);
                  errs++;
               end
               if (rsp_soc_percent !== want.soc_percent) begin
                  $display("%0t: soc_percent expected %0d actual %0d", $time,
                           want.soc_percent, rsp_soc_percent);
                  errs++;
               end
            end
         end

         // request transaction
         if (req_valid && !req_stall)
            readings_due.push_back(compensated_reading(req_battery_mv, req_battery_ma,
                                                       req_charging));

         // register access phase
         if (psel && penable && pready) begin
            mapped = 1'b1;
            reg_now = '0;
            case (paddr[3:2])
               REG_BATTERY_SELECT: reg_now = DATA_W'(select_q);
               REG_RES_FIRST:      reg_now = DATA_W'(res_first_q);
               REG_RES_SECOND:     reg_now = DATA_W'(res_second_q);
               default:            mapped = 1'b0;
            endcase
            if (pwrite) begin
               case (paddr[3:2])
                  REG_BATTERY_SELECT: select_q     = pwdata[0];
                  REG_RES_FIRST:      res_first_q  = pwdata[RES_W-1:0];
                  REG_RES_SECOND:     res_second_q = pwdata[RES_W-1:0];
                  default: ;
               endcase
            end else if (mapped && prdata !== reg_now) begin
               $display("%0t: register %0d read expected %0d actual %0d", $time,
                        paddr[3:2], reg_now, prdata);
               errs++;
            end
         end

         mismatch_count       <= mismatch_count + errs;
         readings_outstanding <= readings_due.size();
      end
   end

endmodule

@@ tb/sv/battery_soc_from_voltage_core_test.sv @@
// ----------------------------------------------------------------------------
// Battery SoC core testbench
// Drives voltage/current readings through the SoC core under random sender
// gaps and receiver stalls, reprograms the battery selection and resistances
// between phases, and leaves prediction and comparison to the reading checker.
// ----------------------------------------------------------------------------
module battery_soc_from_voltage_core_test;
   import bsoc_pkg::*;

   localparam int unsigned STALL_LIMIT    = 4000;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned BLOCK_READINGS = 87;
   localparam logic [1:0]  REG_UNMAPPED   = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [MV_W-1:0]     req_battery_mv = '0;
   logic [MA_W-1:0]     req_battery_ma = '0;
   logic                req_charging = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [MV_W-1:0]     rsp_compensated_mv;
   logic [PCT_W-1:0]    rsp_soc_percent;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   int unsigned mismatch_count;
   int unsigned readings_outstanding;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned quiet_cycles = 0;

   battery_soc_from_voltage_core dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_battery_mv, .req_battery_ma, .req_charging,
      .rsp_valid, .rsp_stall, .rsp_compensated_mv, .rsp_soc_percent,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   bsoc_reading_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_battery_mv, .req_battery_ma, .req_charging,
      .rsp_valid, .rsp_stall, .rsp_compensated_mv, .rsp_soc_percent,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .mismatch_count, .readings_outstanding
   );

   always #4 clock = ~clock;

   // receiver stalls
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog: cycles with no transaction on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("battery_soc_from_voltage_core_test: FAIL");
            $finish;
         end
      end
   end

   task automatic send_reading(input logic [MV_W-1:0] mv, input logic [MA_W-1:0] ma,
                               input logic chg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_battery_mv <= mv;
      req_battery_ma <= ma;
      req_charging   <= chg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait for every outstanding reading to come back
   task automatic drain_readings();
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_outstanding != 0) @(posedge clock);
   endtask

   // setup and access phase, then the bus goes idle
   task automatic csr_access(input logic [1:0] idx, input logic wr,
                             input logic [DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_all_regs();
      csr_access(REG_BATTERY_SELECT, 1'b0, '0);
      csr_access(REG_RES_FIRST, 1'b0, '0);
      csr_access(REG_RES_SECOND, 1'b0, '0);
   endtask

   function automatic logic [RES_W-1:0] pick_resistance();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         default: return RES_W'($urandom_range(1023));
      endcase
   endfunction

   // mostly voltages across the curves with modest drops, then full range
   // and the field extremes
   task automatic send_random_reading();
      int unsigned kind;
      logic [MV_W-1:0] mv;
      logic [MA_W-1:0] ma;
      kind = $urandom_range(99);
      if (kind < 65) begin
         mv = MV_W'($urandom_range(4400, 3550));
         ma = MA_W'($urandom_range(400));
      end else if (kind < 85) begin
         mv = MV_W'($urandom_range(8191));
         ma = MA_W'($urandom_range(8191));
      end else begin
         case ($urandom_range(2))
            0:       mv = '0;
            1:       mv = '1;
            default: mv = MV_W'($urandom_range(4330, 3600));
         endcase
         case ($urandom_range(2))
            0:       ma = '0;
            1:       ma = '1;
            default: ma = MA_W'($urandom_range(8191));
         endcase
      end
      send_reading(mv, ma, 1'($urandom_range(1)));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 38;
      stall_pct = 88;

      // reset values, then the second curve at its edges
      read_all_regs();
      send_reading(13'd8191, 13'd8191, 1'b0);
      send_reading(13'd0,    13'd8191, 1'b1);
      send_reading(13'd100,  13'd8191, 1'b1);
      send_reading(13'd8191, 13'd0,    1'b1);
      send_reading(13'd4227, 13'd0,    1'b0);
      send_reading(13'd4226, 13'd0,    1'b1);
      send_reading(13'd3608, 13'd0,    1'b0);
      send_reading(13'd3607, 13'd0,    1'b1);
      send_reading(13'd3609, 13'd0,    1'b0);
      send_reading(13'd3800, 13'd1000, 1'b1);
      send_reading(13'd3700, 13'd1000, 1'b0);
      drain_readings();

      // upper data bits are dropped; the unmapped register changes nothing
      csr_access(REG_BATTERY_SELECT, 1'b1, 32'hFFFF_FFFE);
      csr_access(REG_RES_FIRST,      1'b1, 32'hFFFF_FFFF);
      csr_access(REG_RES_SECOND,     1'b1, 32'hFFFF_FC00);
      csr_access(REG_UNMAPPED,       1'b1, 32'hFFFF_FFFF);
      read_all_regs();

      // first curve at its edges, maximum resistance
      send_reading(13'd4321, 13'd0,    1'b0);
      send_reading(13'd4320, 13'd0,    1'b1);
      send_reading(13'd3628, 13'd0,    1'b0);
      send_reading(13'd3627, 13'd0,    1'b1);
      send_reading(13'd3629, 13'd0,    1'b0);
      send_reading(13'd3000, 13'd1000, 1'b0);
      send_reading(13'd5000, 13'd1000, 1'b1);
      send_reading(13'd7800, 13'd8191, 1'b0);
      send_reading(13'd4000, 13'd8191, 1'b1);

      // random phases: three idle modes, three register settings each
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 38; stall_pct = 88; end
            1: begin send_idle_pct = 88; stall_pct = 38; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         for (int blk = 0; blk < 3; blk++) begin
            drain_readings();
            csr_access(REG_BATTERY_SELECT, 1'b1,
                       ($urandom() & 32'hFFFF_FFFE) | ((mode + blk) % 2));
            csr_access(REG_RES_FIRST, 1'b1,
                       ($urandom() & 32'hFFFF_FC00) | pick_resistance());
            csr_access(REG_RES_SECOND, 1'b1,
                       ($urandom() & 32'hFFFF_FC00) | pick_resistance());
            read_all_regs();
            for (int k = 0; k < BLOCK_READINGS; k++) begin
               if ($urandom_range(199) == 0) drain_readings();
               send_random_reading();
            end
         end
      end

      drain_readings();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && readings_outstanding == 0) begin
         $display("battery_soc_from_voltage_core_test: PASS");
      end else begin
         $display("battery_soc_from_voltage_core_test: FAIL");
      end
      $finish;
   end

endmodule

@@ battery_soc_from_voltage_core.f @@
hdl/bsoc_pkg.sv
hdl/bsoc_front.sv
hdl/bsoc_queue.sv
hdl/bsoc_back.sv
hdl/battery_soc_from_voltage_core.sv
tb/sv/bsoc_reading_checker.sv
tb/sv/battery_soc_from_voltage_core_test.sv
